// File: hw/rtl/tdvl_pkg.sv
package tdvl_pkg;

    // Default sizes of the place cell grid
    localparam int GRID_WIDTH_DEF  = 16;
    localparam int CELL_COUNT_DEF  = 256;
    localparam int DRIVE_COUNT_DEF = 4;

    // Fixed field widths
    localparam int RADIUS_W = 6;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 16;
    localparam int TD_W     = 18;
    localparam int SHARE_W  = FRAC_W + TD_W;
    localparam int POS_W    = 4;
    localparam int DRIVE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Largest activity a cell can have, also the last entry of the share table
    localparam int ACT_MAX = (1 << RADIUS_W) - 1;

    localparam logic signed [TD_W-1:0] TD_MAX = TD_W'(131071);
    localparam logic signed [TD_W-1:0] TD_MIN = TD_W'(-131072);

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RST     = 6'd4;
    localparam logic [15:0]         DISCOUNT_RST   = 16'd58982;
    localparam logic [15:0]         LEARN_RATE_RST = 16'd6554;
    localparam logic [15:0]         WEIGHT_MAX_RST = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS     = 2'd0,
        CFG_DISCOUNT   = 2'd1,
        CFG_LEARN_RATE = 2'd2,
        CFG_WEIGHT_MAX = 2'd3
    } tdvl_cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_WALK_CUR,
        S_DIV_CUR,
        S_WALK_PREV,
        S_DIV_PREV,
        S_TD,
        S_SHARE_GO,
        S_DIV_SHARE,
        S_TABLE,
        S_UPDATE,
        S_FINISH
    } tdvl_state_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [15:0]         discount;
        logic [15:0]         learn_rate;
        logic [15:0]         weight_max;
    } tdvl_cfg_t;

    typedef struct packed {
        logic load;
        logic walk_start;
        logic walk_prev;
        logic walk_update;
        logic div_start;
        logic div_share;
        logic save_cur;
        logic save_prev;
        logic save_td;
        logic table_start;
        logic out_load;
    } tdvl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
        logic table_done;
        logic clear_busy;
        logic learn;
        logic satisfied;
        logic den_zero;
        logic out_free;
    } tdvl_status_t;

endpackage

// File: hw/rtl/tdvl_div.sv
module tdvl_div #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   rem_next;

    // Restoring division, one quotient bit a cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= rem_next[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/tdvl_dpath.sv
module tdvl_dpath #(
    parameter int GRID_WIDTH  = 16,
    parameter int CELL_COUNT  = 256,
    parameter int DRIVE_COUNT = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tdvl_pkg::tdvl_cmd_t             cmd,
    output tdvl_pkg::tdvl_status_t          status,
    input  tdvl_pkg::tdvl_cfg_t             cfg,
    input  logic                            command,
    input  logic [tdvl_pkg::DRIVE_W-1:0]    drive,
    input  logic [tdvl_pkg::POS_W-1:0]      prev_x,
    input  logic [tdvl_pkg::POS_W-1:0]      prev_y,
    input  logic [tdvl_pkg::POS_W-1:0]      cur_x,
    input  logic [tdvl_pkg::POS_W-1:0]      cur_y,
    input  logic signed [15:0]              reward,
    input  logic                            satisfied,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [tdvl_pkg::WEIGHT_W-1:0]   value,
    output logic signed [tdvl_pkg::TD_W-1:0] td_error
);

    import tdvl_pkg::*;

    localparam int CW     = $clog2(CELL_COUNT);
    localparam int CTR_W  = CW + 1;
    localparam int PW     = CW + 1;
    localparam int DW     = (PW + 1 > RADIUS_W + 1) ? PW + 1 : RADIUS_W + 1;
    localparam int DEPTH  = DRIVE_COUNT * CELL_COUNT;
    localparam int AW     = $clog2(DEPTH);
    localparam int NUM_W  = WEIGHT_W + RADIUS_W + CW;
    localparam int DEN_W  = RADIUS_W + CW;
    localparam int DVS_W  = DEN_W + FRAC_W;
    localparam int DVD_W  = (NUM_W > SHARE_W) ? NUM_W : SHARE_W;
    localparam int ACCQ_W = TD_W + RADIUS_W;

    // Weight store and table of per-activity weight changes
    logic [WEIGHT_W-1:0] wmem [DEPTH];
    logic [TD_W-1:0]     ctab [ACT_MAX + 1];

    // Latched request
    logic                learn_reg;
    logic                sat_reg;
    logic [POS_W-1:0]    px_reg, py_reg, cx_reg, cy_reg;
    logic signed [15:0]  reward_reg;
    logic [AW-1:0]       base_reg;

    // Cell walk
    logic                walk_busy_reg;
    logic                walk_prev_reg;
    logic                walk_upd_reg;
    logic [CTR_W-1:0]    cnt_reg;
    logic [PW-1:0]       col_reg;
    logic [PW-1:0]       rowp_reg;
    logic                vld_q_reg;
    logic [RADIUS_W-1:0] a_q_reg;
    logic [AW-1:0]       addr_q_reg;
    logic [WEIGHT_W-1:0] rdata_reg;
    logic [TD_W-1:0]     tdata_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;

    logic [WEIGHT_W-1:0]  cur_val_reg;
    logic [WEIGHT_W-1:0]  pred_reg;
    logic signed [TD_W-1:0] delta_reg;

    // Share table build
    logic                tbl_busy_reg;
    logic [RADIUS_W-1:0] tcnt_reg;
    logic [ACCQ_W-1:0]   accq_reg;
    logic [DVS_W:0]      accr_reg;

    // Clearing pass
    logic                clr_busy_reg;
    logic [AW:0]         clr_cnt_reg;

    logic                out_valid_reg;
    logic [WEIGHT_W-1:0] value_out_reg;
    logic [TD_W-1:0]     td_out_reg;

    // Combinational
    logic [DRIVE_W-1:0]  row_mod;
    logic                issue;
    logic [AW-1:0]       addr_issue;
    logic [PW-1:0]       pos_x, pos_y;
    logic [PW-1:0]       dx, dy;
    logic [DW-1:0]       dist_sum;
    logic [RADIUS_W-1:0] act;
    logic                walk_done;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;
    logic [DVS_W-1:0]    div_rem;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    logic [DVS_W-1:0]    share_den;
    logic [WEIGHT_W-1:0] value_q;
    logic [31:0]         boot_prod;
    logic signed [TD_W:0] diff;
    logic signed [TD_W-1:0] delta_next;
    logic [TD_W-1:0]     delta_abs;
    logic [SHARE_W-1:0]  share_prod;
    logic [DVS_W:0]      sum_r;
    logic                carry;
    logic [DVS_W:0]      accr_next;
    logic [ACCQ_W-1:0]   accq_next;
    logic signed [TD_W+1:0] change;
    logic signed [TD_W+1:0] new_w;
    logic [WEIGHT_W-1:0] clamped;
    logic                upd_we;

    always_comb
    begin
        row_mod = drive;
        for (int i = 0; i < 4; i++)
        begin
            if (32'(row_mod) >= DRIVE_COUNT)
            begin
                row_mod = DRIVE_W'(32'(row_mod) - DRIVE_COUNT);
            end
        end
    end

    // Activity of the cell being issued
    always_comb
    begin
        pos_x    = walk_prev_reg ? PW'(px_reg) : PW'(cx_reg);
        pos_y    = walk_prev_reg ? PW'(py_reg) : PW'(cy_reg);
        dx       = (col_reg >= pos_x) ? (col_reg - pos_x) : (pos_x - col_reg);
        dy       = (rowp_reg >= pos_y) ? (rowp_reg - pos_y) : (pos_y - rowp_reg);
        dist_sum = DW'(dx) + DW'(dy);
        act      = (dist_sum < DW'(cfg.radius)) ? RADIUS_W'(DW'(cfg.radius) - dist_sum) : '0;
    end

    assign issue      = walk_busy_reg && (cnt_reg != CTR_W'(CELL_COUNT));
    assign addr_issue = base_reg + AW'(cnt_reg[CW-1:0]);
    assign walk_done  = walk_busy_reg && (cnt_reg == CTR_W'(CELL_COUNT)) && !vld_q_reg;

    assign share_den = {den_reg, {FRAC_W{1'b0}}};
    assign delta_abs = delta_reg[TD_W-1] ? TD_W'(-delta_reg) : TD_W'(delta_reg);
    assign share_prod = SHARE_W'(cfg.learn_rate) * SHARE_W'(delta_abs);
    assign div_dvd   = cmd.div_share ? DVD_W'(share_prod) : DVD_W'(num_reg);
    assign div_dvs   = cmd.div_share ? share_den : DVS_W'(den_reg);

    tdvl_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign value_q = (den_reg == '0) ? '0 : div_quo[WEIGHT_W-1:0];

    // TD error from the bootstrapped target and the prediction
    always_comb
    begin
        boot_prod = 32'(cfg.discount) * 32'(cur_val_reg);
        diff = (TD_W+1)'(reward_reg) + $signed({3'b000, boot_prod[31:16]})
               - $signed({3'b000, pred_reg});
        if (diff > (TD_W+1)'(TD_MAX))
        begin
            delta_next = TD_MAX;
        end
        else if (diff < (TD_W+1)'(TD_MIN))
        begin
            delta_next = TD_MIN;
        end
        else
        begin
            delta_next = diff[TD_W-1:0];
        end
    end

    // Each table entry adds one share quotient and remainder to the last,
    // the remainder staying below the divisor.
    always_comb
    begin
        sum_r     = accr_reg + (DVS_W+1)'(div_rem);
        carry     = sum_r >= {1'b0, share_den};
        accr_next = carry ? (sum_r - {1'b0, share_den}) : sum_r;
        accq_next = accq_reg + ACCQ_W'(div_quo[TD_W-1:0]) + ACCQ_W'(carry);
    end

    // Weight update with truncation toward zero and clamping
    always_comb
    begin
        change = delta_reg[TD_W-1] ? -$signed({2'b00, tdata_reg})
                                   : $signed({2'b00, tdata_reg});
        new_w  = $signed({{(TD_W+2-WEIGHT_W){1'b0}}, rdata_reg}) + change;
        if (new_w < 0)
        begin
            clamped = '0;
        end
        else if (new_w > $signed({{(TD_W+2-WEIGHT_W){1'b0}}, cfg.weight_max}))
        begin
            clamped = cfg.weight_max;
        end
        else
        begin
            clamped = new_w[WEIGHT_W-1:0];
        end
        upd_we = vld_q_reg && walk_upd_reg && (a_q_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg <= 1'b0;
            vld_q_reg     <= 1'b0;
            tbl_busy_reg  <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (cmd.walk_start)
            begin
                walk_busy_reg <= 1'b1;
            end
            else if (walk_done)
            begin
                walk_busy_reg <= 1'b0;
            end
            vld_q_reg <= issue;

            if (cmd.table_start)
            begin
                tbl_busy_reg <= 1'b1;
            end
            else if (tbl_busy_reg && tcnt_reg == RADIUS_W'(ACT_MAX))
            begin
                tbl_busy_reg <= 1'b0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            learn_reg   <= command;
            sat_reg     <= satisfied;
            px_reg      <= prev_x;
            py_reg      <= prev_y;
            cx_reg      <= cur_x;
            cy_reg      <= cur_y;
            reward_reg  <= reward;
            base_reg    <= AW'(32'(row_mod) * CELL_COUNT);
            cur_val_reg <= '0;
        end
        else if (cmd.save_cur)
        begin
            cur_val_reg <= value_q;
        end

        if (cmd.save_prev)
        begin
            pred_reg <= value_q;
        end
        if (cmd.save_td)
        begin
            delta_reg <= delta_next;
        end

        if (cmd.walk_start)
        begin
            walk_prev_reg <= cmd.walk_prev;
            walk_upd_reg  <= cmd.walk_update;
            cnt_reg       <= '0;
            col_reg       <= '0;
            rowp_reg      <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
        end
        else
        begin
            if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (col_reg == PW'(GRID_WIDTH - 1))
                begin
                    col_reg  <= '0;
                    rowp_reg <= rowp_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (vld_q_reg)
            begin
                num_reg <= num_reg + NUM_W'(a_q_reg) * NUM_W'(rdata_reg);
                den_reg <= den_reg + DEN_W'(a_q_reg);
            end
        end
        a_q_reg    <= act;
        addr_q_reg <= addr_issue;

        if (cmd.table_start)
        begin
            tcnt_reg <= RADIUS_W'(1);
            accq_reg <= '0;
            accr_reg <= '0;
        end
        else if (tbl_busy_reg)
        begin
            tcnt_reg <= tcnt_reg + 1'b1;
            accq_reg <= accq_next;
            accr_reg <= accr_next;
        end

        if (cmd.out_load)
        begin
            value_out_reg <= learn_reg ? pred_reg : cur_val_reg;
            td_out_reg    <= learn_reg ? delta_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= wmem[addr_issue];
        if (clr_busy_reg)
        begin
            wmem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (upd_we)
        begin
            wmem[addr_q_reg] <= clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= ctab[act];
        if (tbl_busy_reg)
        begin
            ctab[tcnt_reg] <= accq_next[TD_W-1:0];
        end
    end

    always_comb
    begin
        status.walk_done  = walk_done;
        status.div_done   = div_done;
        status.table_done = tbl_busy_reg && (tcnt_reg == RADIUS_W'(ACT_MAX));
        status.clear_busy = clr_busy_reg;
        status.learn      = learn_reg;
        status.satisfied  = sat_reg;
        status.den_zero   = (den_reg == '0);
        status.out_free   = !out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_out_reg;
    assign td_error  = td_out_reg;

endmodule

// File: hw/rtl/tdvl_ctrl.sv
module tdvl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  tdvl_pkg::tdvl_status_t status,
    output tdvl_pkg::tdvl_cmd_t    cmd
);

    import tdvl_pkg::*;

    tdvl_state_t state_reg;
    tdvl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                if (!status.clear_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.walk_start = 1'b1;
                if (status.learn && status.satisfied)
                begin
                    cmd.walk_prev = 1'b1;
                    state_next    = S_WALK_PREV;
                end
                else
                begin
                    state_next = S_WALK_CUR;
                end
            end
            S_WALK_CUR:
            begin
                if (status.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_CUR;
                end
            end
            S_DIV_CUR:
            begin
                if (status.div_done)
                begin
                    cmd.save_cur = 1'b1;
                    if (status.learn)
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_prev  = 1'b1;
                        state_next     = S_WALK_PREV;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_WALK_PREV:
            begin
                if (status.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_PREV;
                end
            end
            S_DIV_PREV:
            begin
                if (status.div_done)
                begin
                    cmd.save_prev = 1'b1;
                    state_next    = S_TD;
                end
            end
            S_TD:
            begin
                cmd.save_td = 1'b1;
                state_next  = status.den_zero ? S_FINISH : S_SHARE_GO;
            end
            S_SHARE_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_share = 1'b1;
                state_next    = S_DIV_SHARE;
            end
            S_DIV_SHARE:
            begin
                if (status.div_done)
                begin
                    cmd.table_start = 1'b1;
                    state_next      = S_TABLE;
                end
            end
            S_TABLE:
            begin
                if (status.table_done)
                begin
                    cmd.walk_start  = 1'b1;
                    cmd.walk_prev   = 1'b1;
                    cmd.walk_update = 1'b1;
                    state_next      = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (status.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/td_value_learning_place_cells.sv
// A query takes one walk over the weight row and one division; a learning step takes
// up to three walks over the weight row at one cell a cycle, up to three divisions and
// a 63-step share table, fewer when the drive is satisfied. One request is worked on at
// a time; the next is taken while a result waits. After reset every entry of the weight
// store is cleared and no request is taken until then.
module td_value_learning_place_cells #(
    parameter int GRID_WIDTH  = tdvl_pkg::GRID_WIDTH_DEF,
    parameter int CELL_COUNT  = tdvl_pkg::CELL_COUNT_DEF,
    parameter int DRIVE_COUNT = tdvl_pkg::DRIVE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [tdvl_pkg::DRIVE_W-1:0]        drive,
    input  logic [tdvl_pkg::POS_W-1:0]          prev_x,
    input  logic [tdvl_pkg::POS_W-1:0]          prev_y,
    input  logic [tdvl_pkg::POS_W-1:0]          cur_x,
    input  logic [tdvl_pkg::POS_W-1:0]          cur_y,
    input  logic signed [15:0]                  reward,
    input  logic                                satisfied,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tdvl_pkg::WEIGHT_W-1:0]       value,
    output logic signed [tdvl_pkg::TD_W-1:0]    td_error,
    input  logic                                cfg_we,
    input  logic [tdvl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdvl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import tdvl_pkg::*;

    tdvl_cfg_t    cfg_reg;
    tdvl_cmd_t    cmd;
    tdvl_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius     <= RADIUS_RST;
            cfg_reg.discount   <= DISCOUNT_RST;
            cfg_reg.learn_rate <= LEARN_RATE_RST;
            cfg_reg.weight_max <= WEIGHT_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:     cfg_reg.radius     <= cfg_wdata[RADIUS_W-1:0];
                CFG_DISCOUNT:   cfg_reg.discount   <= cfg_wdata;
                CFG_LEARN_RATE: cfg_reg.learn_rate <= cfg_wdata;
                CFG_WEIGHT_MAX: cfg_reg.weight_max <= cfg_wdata;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    tdvl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tdvl_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .CELL_COUNT  (CELL_COUNT),
        .DRIVE_COUNT (DRIVE_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_reg),
        .command   (command),
        .drive     (drive),
        .prev_x    (prev_x),
        .prev_y    (prev_y),
        .cur_x     (cur_x),
        .cur_y     (cur_y),
        .reward    (reward),
        .satisfied (satisfied),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .value     (value),
        .td_error  (td_error)
    );

endmodule
